// File: hdl/rlbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlbm_pkg
// shared types, character codes and helpers of the range list to bitmask
// parser
// ----------------------------------------------------------------------------
package rlbm_pkg;

  localparam int unsigned MaskBitsDefault = 32;
  localparam int unsigned OutMaskW        = 32;
  localparam int unsigned CharW           = 8;
  localparam int unsigned CountW          = 4;
  localparam int unsigned IdxW            = 3;
  localparam int unsigned DecW            = 9;
  localparam int unsigned MaxArgs         = 8;
  localparam int unsigned HandleSteps     = 3;
  localparam int unsigned ResDepth        = 4;
  localparam int unsigned ResPtrW         = 2;
  localparam int unsigned ResCntW         = 3;

  localparam logic [DecW-1:0]  DecMax     = 9'd511;
  localparam logic [CharW-1:0] ChNul      = 8'h00;
  localparam logic [CharW-1:0] ChOpen     = 8'h28;
  localparam logic [CharW-1:0] ChClose    = 8'h29;
  localparam logic [CharW-1:0] ChComma    = 8'h2c;
  localparam logic [CharW-1:0] ChSpace    = 8'h20;
  localparam logic [CharW-1:0] ChDash     = 8'h2d;
  localparam logic [CharW-1:0] ChDot      = 8'h2e;
  localparam logic [CharW-1:0] ChZero     = 8'h30;

  localparam logic KindMask   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [7:0] {
    PH_ARG    = 8'b0000_0001,
    PH_HEAD   = 8'b0000_0010,
    PH_NUM    = 8'b0000_0100,
    PH_WORD   = 8'b0000_1000,
    PH_RFIRST = 8'b0001_0000,
    PH_RNUM   = 8'b0010_0000,
    PH_DOT    = 8'b0100_0000,
    PH_CLOSE  = 8'b1000_0000
  } phase_e;

  function automatic logic is_dig(input logic [CharW-1:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_aln(input logic [CharW-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]});
  endfunction

  function automatic logic [DecW-1:0] dig_val(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    d = c - ChZero;
    return DecW'(d[3:0]);
  endfunction

  function automatic logic [DecW-1:0] dec_acc(input logic [DecW-1:0] v,
                                              input logic [CharW-1:0] c);
    logic [DecW+3:0] n;
    n = ({4'd0, v} * 13'd10) + {4'd0, dig_val(c)};
    return (n > {4'd0, DecMax}) ? DecMax : n[DecW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/range_list_to_bitmask_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_list_to_bitmask_parser_core
// parses a range list string, one character per word, into argument masks
// and a final status
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one character per word in tdata[7:0]; tlast marks the end
//   of the string (the character is then read as nul). cfg_we_i/cfg_wdata_i
//   write the argument count.
//   m_axis carries results: tuser is the kind (0 mask, 1 status), tdata holds
//   arg_index, bit_mask and parse_ok, tlast flags the last result of a word.
//   each character is parsed in the cycle it is accepted; its results (zero,
//   one or two) sit in a four entry result queue and show on m_axis from the
//   next cycle, one per cycle while m_axis_tready is high.
//   throughput is one character per cycle while the queue holds two results
//   or fewer; a character that gives two results needs two output transfers,
//   so the queue depth and the receiver rate set the sustained input rate.
//   when the receiver stalls, results wait in the queue and s_axis_tready
//   drops once more than two are pending.
//   reset clears the parser state, empties the queue and sets the argument
//   count to one. the end of a string returns the parser to its reset state
//   but keeps the argument count.
// ----------------------------------------------------------------------------
module range_list_to_bitmask_parser_core
  import rlbm_pkg::*;
#(
  parameter int unsigned MASK_BITS = MaskBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CountW-1:0]   cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // char_in
  input  wire logic                s_axis_tlast,   // end_marker
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [39:0]              m_axis_tdata,   // arg_index, bit_mask, parse_ok, zero pad
  output logic                     m_axis_tuser,   // kind
  output logic                     m_axis_tlast    // last_result
);

  typedef struct packed {
    phase_e                phase;
    logic [IdxW-1:0]       args_done;
    logic [MASK_BITS-1:0]  acc;
    logic [DecW-1:0]       low;
    logic [DecW-1:0]       high;
    logic                  low_alpha;
    logic                  in_parens;
    logic                  list_allowed;
    logic                  finished;
  } state_t;

  typedef struct packed {
    logic                  kind;
    logic [IdxW-1:0]       idx;
    logic [MASK_BITS-1:0]  mask;
    logic                  ok;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } rlist_t;

  function automatic state_t st_reset();
    state_t s;
    s       = '0;
    s.phase = PH_ARG;
    return s;
  endfunction

  function automatic rlist_t push(input rlist_t l, input res_t r);
    rlist_t o;
    o = l;
    if (l.n == 2'd0) begin
      o.r0 = r;
      o.n  = 2'd1;
    end else if (l.n == 2'd1) begin
      o.r1 = r;
      o.n  = 2'd2;
    end
    return o;
  endfunction

  function automatic res_t mk_status(input logic ok);
    res_t r;
    r      = '0;
    r.kind = KindStatus;
    r.ok   = ok;
    return r;
  endfunction

  function automatic res_t mk_mask(input logic [IdxW-1:0] idx,
                                   input logic [MASK_BITS-1:0] m);
    res_t r;
    r      = '0;
    r.kind = KindMask;
    r.idx  = idx;
    r.mask = m;
    return r;
  endfunction

  function automatic logic [MASK_BITS-1:0] fill(input logic [DecW:0] v,
                                                input logic [DecW-1:0] r);
    logic [MASK_BITS-1:0] m;
    for (int i = 0; i < MASK_BITS; i++) begin
      m[i] = (int'(v) <= i) && (i <= int'(r));
    end
    return m;
  endfunction

  logic [CountW-1:0]  arg_count_q;
  logic [CountW-1:0]  eff_count;
  state_t             state_q, state_d, st;
  rlist_t             rl;
  logic [CharW-1:0]   ch;
  logic               nul;
  logic               consumed;
  logic               last_arg;
  logic               in_acc, out_acc;
  logic               post_skip;
  logic [DecW:0]      post_v;
  logic [DecW-1:0]    post_r;
  logic               do_post;
  logic [CharW-1:0]   matchc;

  res_t               fifo_q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0] cnt_q;
  res_t               head;

  assign eff_count = (arg_count_q > CountW'(MaxArgs)) ? CountW'(MaxArgs) : arg_count_q;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;

  always_comb begin
    st        = state_q;
    rl        = '0;
    ch        = s_axis_tlast ? ChNul : s_axis_tdata;
    nul       = (ch == ChNul);
    consumed  = 1'b0;
    last_arg  = 1'b0;
    post_skip = 1'b0;
    post_v    = '0;
    post_r    = '0;
    do_post   = 1'b0;
    matchc    = ChComma;
    if (!st.finished && ({1'b0, st.args_done} >= eff_count)) begin
      rl          = push(rl, mk_status(1'b1));
      st.finished = 1'b1;
    end
    for (int k = 0; k < HandleSteps; k++) begin
      if (!st.finished && !consumed) begin
        do_post  = 1'b0;
        last_arg = ({1'b0, st.args_done} + CountW'(1)) >= eff_count;
        case (st.phase)
          PH_ARG: begin
            if (ch == ChSpace) begin
              consumed = 1'b1;
            end else if (ch == ChOpen) begin
              st.in_parens    = 1'b1;
              st.list_allowed = 1'b1;
              st.acc          = '0;
              st.phase        = PH_HEAD;
              consumed        = 1'b1;
            end else if (is_aln(ch)) begin
              st.in_parens    = 1'b0;
              st.list_allowed = last_arg;
              st.acc          = '0;
              st.phase        = PH_HEAD;
            end else begin
              rl          = push(rl, mk_status(1'b0));
              st.finished = 1'b1;
              consumed    = 1'b1;
            end
          end
          PH_HEAD: begin
            matchc = st.in_parens ? ChClose : ChComma;
            if (nul || ch == matchc) begin
              st.phase = (!nul && st.in_parens) ? PH_CLOSE : PH_ARG;
              rl       = push(rl, mk_mask(st.args_done, st.acc));
              if (last_arg) begin
                rl          = push(rl, mk_status(1'b1));
                st.finished = 1'b1;
              end else begin
                st.args_done = st.args_done + IdxW'(1);
              end
              consumed = !nul;
            end else if (ch == ChSpace) begin
              consumed = 1'b1;
            end else if (!is_aln(ch)) begin
              rl          = push(rl, mk_status(1'b0));
              st.finished = 1'b1;
              consumed    = 1'b1;
            end else begin
              st.low_alpha = !is_dig(ch);
              st.low       = is_dig(ch) ? dig_val(ch) : '0;
              st.phase     = is_dig(ch) ? PH_NUM : PH_WORD;
              consumed     = 1'b1;
            end
          end
          PH_NUM, PH_WORD: begin
            if ((st.phase == PH_NUM) ? is_dig(ch) : is_aln(ch)) begin
              if (st.phase == PH_NUM) begin
                st.low = dec_acc(st.low, ch);
              end
              consumed = 1'b1;
            end else if (ch == ChDash) begin
              st.phase = PH_RFIRST;
              consumed = 1'b1;
            end else if (ch == ChDot) begin
              st.phase = PH_DOT;
              consumed = 1'b1;
            end else begin
              do_post   = 1'b1;
              post_skip = st.low_alpha;
              post_v    = {1'b0, st.low};
              post_r    = st.low;
            end
          end
          PH_RFIRST: begin
            if (!is_dig(ch)) begin
              rl          = push(rl, mk_status(1'b0));
              st.finished = 1'b1;
            end else begin
              st.high  = dig_val(ch);
              st.phase = PH_RNUM;
            end
            consumed = 1'b1;
          end
          PH_RNUM: begin
            if (is_dig(ch)) begin
              st.high  = dec_acc(st.high, ch);
              consumed = 1'b1;
            end else begin
              do_post   = 1'b1;
              post_skip = st.low_alpha;
              post_v    = {1'b0, st.low};
              post_r    = st.high;
            end
          end
          PH_DOT: begin
            if (is_dig(ch)) begin
              consumed = 1'b1;
            end else begin
              do_post   = 1'b1;
              post_skip = 1'b0;
              post_v    = st.low_alpha ? '0 : ({1'b0, st.low} + (DecW+1)'(1));
              post_r    = st.low_alpha ? '0 : DecMax;
            end
          end
          default: begin
            st.phase = PH_ARG;
            consumed = (ch == ChComma);
          end
        endcase
        if (do_post) begin
          if (!post_skip) begin
            if (st.phase == PH_DOT && !st.low_alpha) begin
              st.acc = st.acc | fill(post_v, post_v[DecW-1:0] | {DecW{post_v[DecW]}});
            end else begin
              st.acc = st.acc | fill(post_v, post_r);
            end
          end
          st.phase = PH_HEAD;
          consumed = st.list_allowed && (ch == ChComma);
        end
      end
    end
    if (rl.n == 2'd1) begin
      rl.r0.last = 1'b1;
    end else if (rl.n == 2'd2) begin
      rl.r1.last = 1'b1;
    end
    state_d = st;
    if (nul) begin
      state_d = st_reset();
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arg_count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      arg_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= st_reset();
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  assign s_axis_tready = (cnt_q <= ResCntW'(ResDepth - 2));

  always_ff @(posedge clk_i) begin
    if (in_acc && rl.n != 2'd0) begin
      fifo_q[wr_ptr_q] <= rl.r0;
    end
    if (in_acc && rl.n == 2'd2) begin
      fifo_q[wr_ptr_q + ResPtrW'(1)] <= rl.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + ResPtrW'(rl.n);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + ResPtrW'(1);
      end
      cnt_q <= cnt_q + (in_acc ? ResCntW'(rl.n) : '0) - ResCntW'(out_acc);
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  generate
    if (MASK_BITS >= OutMaskW) begin : g_mask_trunc
      assign m_axis_tdata = {4'd0, head.ok, head.mask[OutMaskW-1:0], head.idx};
    end else begin : g_mask_ext
      assign m_axis_tdata = {4'd0, head.ok, {(OutMaskW-MASK_BITS){1'b0}}, head.mask,
                             head.idx};
    end
  endgenerate

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result queue overflow");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (state_q.phase == PH_ARG && state_q.args_done == '0
                                   && !state_q.finished))
    else $error("parser state not cleared at end of string");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KindStatus) |-> m_axis_tlast)
    else $error("status result is not the last of its word");

  a_mask_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KindMask) |-> !m_axis_tdata[35])
    else $error("mask result carries a status flag");

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the range list to bitmask parser: range list
// strings go in one character per word, every mask and status word that
// comes out is compared against a cycle-free model of the parser, with
// random gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
module tb_top;
  import rlbm_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomChars = 480;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             eom;
  } char_word_t;

  typedef struct {
    logic                kind;
    logic [IdxW-1:0]     idx;
    logic [OutMaskW-1:0] mask;
    logic                ok;
    logic                last;
  } parse_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CountW-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;   // arg_index, bit_mask, parse_ok, zero pad
  logic              m_axis_tuser;   // kind
  logic              m_axis_tlast;   // last_result

  range_list_to_bitmask_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  char_word_t    char_queue[$];
  parse_result_t char_results[$];
  parse_result_t exp_results[$];

  // model state
  phase_e              pr_phase;
  logic [IdxW-1:0]     pr_done;
  logic [OutMaskW-1:0] pr_mask;
  logic [DecW-1:0]     pr_low;
  logic [DecW-1:0]     pr_high;
  bit                  pr_low_alpha;
  bit                  pr_parens;
  bit                  pr_list;
  bit                  pr_finished;
  logic [CountW-1:0]   pr_count = 4'd1;

  int    in_issued    = 0;
  int    in_accepted  = 0;
  int    in_gap       = 0;
  int    out_accepted = 0;
  int    out_seen     = 0;
  int    out_wait     = 0;
  int    err_cnt      = 0;
  int    cycle_cnt    = 0;
  int    chars_queued = 0;
  int    strings_sent = 0;
  int    cur_count    = 1;
  int    count_min    = 15;
  int    count_max    = 0;
  bit    fast_in      = 1'b0;
  bit    fast_out     = 1'b0;
  string alnum_set    = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  function automatic bit digit_char(input logic [CharW-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit alnum_char(input logic [CharW-1:0] c);
    return digit_char(c) || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic int arg_limit();
    return (pr_count > 4'd8) ? 8 : int'(pr_count);
  endfunction

  function automatic logic [DecW-1:0] dec_next(input logic [DecW-1:0] v,
                                               input logic [CharW-1:0] c);
    int n;
    n = int'(v) * 10 + int'(c) - int'(ChZero);
    return (n > int'(DecMax)) ? DecMax : DecW'(n);
  endfunction

  function automatic void parser_clear();
    pr_phase     = PH_ARG;
    pr_done      = '0;
    pr_mask      = '0;
    pr_low       = '0;
    pr_high      = '0;
    pr_low_alpha = 1'b0;
    pr_parens    = 1'b0;
    pr_list      = 1'b0;
    pr_finished  = 1'b0;
  endfunction

  function automatic void add_result(input logic kind, input logic [IdxW-1:0] idx,
                                     input logic [OutMaskW-1:0] mask, input logic ok);
    parse_result_t r;
    if (char_results.size() < 2) begin
      r.kind = kind;
      r.idx  = idx;
      r.mask = mask;
      r.ok   = ok;
      r.last = 1'b0;
      char_results.push_back(r);
    end
  endfunction

  function automatic void finish_parse(input logic ok);
    add_result(KindStatus, '0, '0, ok);
    pr_finished = 1'b1;
  endfunction

  function automatic void close_argument();
    add_result(KindMask, pr_done, pr_mask, 1'b0);
    if (int'(pr_done) + 1 >= arg_limit()) begin
      finish_parse(1'b1);
    end else begin
      pr_done = pr_done + IdxW'(1);
    end
  endfunction

  function automatic bit apply_item(input bit skip, input int lo, input int hi,
                                    input logic [CharW-1:0] c);
    if (!skip) begin
      if (hi > int'(OutMaskW) - 1) hi = int'(OutMaskW) - 1;
      for (int i = lo; i <= hi; i++) pr_mask[i] = 1'b1;
    end
    pr_phase = PH_HEAD;
    return pr_list && (c == ChComma);
  endfunction

  // returns 1 when the character is consumed
  function automatic bit handle_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] closer;
    bit taken;
    taken = 1'b1;
    case (pr_phase)
      PH_ARG: begin
        if (c == ChOpen) begin
          pr_parens = 1'b1;
          pr_list   = 1'b1;
          pr_mask   = '0;
          pr_phase  = PH_HEAD;
        end else if (alnum_char(c)) begin
          pr_parens = 1'b0;
          pr_list   = (int'(pr_done) + 1 >= arg_limit());
          pr_mask   = '0;
          pr_phase  = PH_HEAD;
          taken     = 1'b0;
        end else if (c != ChSpace) begin
          finish_parse(1'b0);
        end
      end
      PH_HEAD: begin
        closer = pr_parens ? ChClose : ChComma;
        if ((c == ChNul) || (c == closer)) begin
          pr_phase = ((c != ChNul) && pr_parens) ? PH_CLOSE : PH_ARG;
          close_argument();
          taken = (c != ChNul);
        end else if (c == ChSpace) begin
          taken = 1'b1;
        end else if (!alnum_char(c)) begin
          finish_parse(1'b0);
        end else begin
          pr_low_alpha = !digit_char(c);
          pr_low       = pr_low_alpha ? '0 : DecW'(c - ChZero);
          pr_phase     = pr_low_alpha ? PH_WORD : PH_NUM;
        end
      end
      PH_NUM, PH_WORD: begin
        if ((pr_phase == PH_NUM) ? digit_char(c) : alnum_char(c)) begin
          if (pr_phase == PH_NUM) pr_low = dec_next(pr_low, c);
        end else if (c == ChDash) begin
          pr_phase = PH_RFIRST;
        end else if (c == ChDot) begin
          pr_phase = PH_DOT;
        end else begin
          taken = apply_item(pr_low_alpha, int'(pr_low), int'(pr_low), c);
        end
      end
      PH_RFIRST: begin
        if (!digit_char(c)) begin
          finish_parse(1'b0);
        end else begin
          pr_high  = DecW'(c - ChZero);
          pr_phase = PH_RNUM;
        end
      end
      PH_RNUM: begin
        if (digit_char(c)) begin
          pr_high = dec_next(pr_high, c);
        end else begin
          taken = apply_item(pr_low_alpha, int'(pr_low), int'(pr_high), c);
        end
      end
      PH_DOT: begin
        if (!digit_char(c)) begin
          if (pr_low_alpha) begin
            taken = apply_item(1'b0, 0, 0, c);
          end else begin
            taken = apply_item(1'b0, int'(pr_low) + 1, int'(pr_low) + 1, c);
          end
        end
      end
      default: begin
        pr_phase = PH_ARG;
        taken    = (c == ChComma);
      end
    endcase
    return taken;
  endfunction

  function automatic void predict_char(input logic [CharW-1:0] ch, input logic eom);
    logic [CharW-1:0] c;
    bit str_end;
    bit taken;
    int guard;
    parse_result_t r;
    c       = eom ? ChNul : ch;
    str_end = (c == ChNul);
    taken   = 1'b0;
    guard   = 0;
    char_results.delete();
    if (!pr_finished && (int'(pr_done) >= arg_limit())) finish_parse(1'b1);
    while ((guard < 16) && !pr_finished && !taken) begin
      taken = handle_char(c);
      guard++;
    end
    if (str_end) parser_clear();
    foreach (char_results[i]) begin
      r      = char_results[i];
      r.last = (i == char_results.size() - 1);
      exp_results.push_back(r);
    end
  endfunction

  task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("error at result %0d: %s expected %0h got %0h", out_accepted, what, want, got);
    end
  endtask

  task automatic check_result();
    parse_result_t e;
    if (exp_results.size() == 0) begin
      flag_error("unexpected word, tdata low bits", '0, m_axis_tdata[31:0]);
    end else begin
      e = exp_results.pop_front();
      if (m_axis_tuser !== e.kind) flag_error("kind", 32'(e.kind), 32'(m_axis_tuser));
      if (m_axis_tdata[2:0] !== e.idx) begin
        flag_error("arg_index", 32'(e.idx), 32'(m_axis_tdata[2:0]));
      end
      if (m_axis_tdata[34:3] !== e.mask) flag_error("bit_mask", e.mask, m_axis_tdata[34:3]);
      if (m_axis_tdata[35] !== e.ok) flag_error("parse_ok", 32'(e.ok), 32'(m_axis_tdata[35]));
      if (m_axis_tdata[39:36] !== 4'd0) flag_error("pad", '0, 32'(m_axis_tdata[39:36]));
      if (m_axis_tlast !== e.last) flag_error("last_result", 32'(e.last), 32'(m_axis_tlast));
    end
    out_accepted++;
  endtask

  // monitor and model update
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_we_i) pr_count = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_char(s_axis_tdata, s_axis_tlast);
        in_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && (in_accepted != in_issued))) begin
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (char_queue.size() > 0) begin
        s_axis_tdata  <= char_queue[0].ch;
        s_axis_tlast  <= char_queue[0].eom;
        s_axis_tvalid <= 1'b1;
        void'(char_queue.pop_front());
        in_issued++;
        in_gap = fast_in ? 0 : $urandom_range(0, 7);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, one stall drawn per word
  always @(negedge clk_i) begin
    if (out_seen != out_accepted) begin
      out_seen = out_accepted;
      out_wait = fast_out ? 0 : $urandom_range(0, 7);
    end
    if (rst_ni && (out_wait == 0)) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (out_wait > 0) out_wait = out_wait - 1;
      m_axis_tready <= 1'b0;
    end
  end

  task automatic wait_idle();
    while ((char_queue.size() != 0) || (in_accepted != in_issued) ||
           (exp_results.size() != 0)) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_count(input int value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CountW'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_count = value;
    if (value < count_min) count_min = value;
    if (value > count_max) count_max = value;
  endtask

  task automatic send_char(input logic [CharW-1:0] ch, input logic eom);
    char_word_t w;
    w.ch  = ch;
    w.eom = eom;
    char_queue.push_back(w);
    chars_queued++;
  endtask

  // mut > 0 replaces about one character in mut by a random byte
  task automatic send_text(input string s, input int mut);
    logic [CharW-1:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if ((mut > 0) && ($urandom_range(0, mut - 1) == 0)) ch = CharW'($urandom_range(0, 255));
      send_char(ch, 1'b0);
    end
  endtask

  task automatic send_end();
    if ($urandom_range(0, 3) == 0) begin
      send_char(ChNul, 1'b0);
    end else begin
      send_char(CharW'($urandom_range(0, 255)), 1'b1);
    end
    strings_sent++;
  endtask

  function automatic string rand_value();
    int r;
    int n;
    string s;
    r = $urandom_range(0, 9);
    if (r < 6) return $sformatf("%0d", $urandom_range(0, 35));
    if (r < 8) return $sformatf("%0d", $urandom_range(0, 600));
    s = "";
    n = $urandom_range(4, 7);
    repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    return s;
  endfunction

  function automatic string rand_word();
    int n;
    string s;
    s = $sformatf("%c", alnum_set[$urandom_range(10, 61)]);
    n = $urandom_range(0, 4);
    repeat (n) s = $sformatf("%s%c", s, alnum_set[$urandom_range(0, 61)]);
    return s;
  endfunction

  function automatic string rand_item();
    string s;
    case ($urandom_range(0, 9))
      0, 1, 2: s = rand_value();
      3, 4, 5: s = {rand_value(), "-", rand_value()};
      6:       s = {rand_value(), ".", $sformatf("%0d", $urandom_range(0, 9))};
      7:       s = rand_word();
      8: begin
        if ($urandom_range(0, 1) == 0) s = {rand_word(), ".", rand_value()};
        else s = {rand_word(), "-", rand_value()};
      end
      default: s = {" ", rand_value(), " "};
    endcase
    return s;
  endfunction

  function automatic string rand_arg(input bit last_arg);
    int n;
    string s;
    if ($urandom_range(0, 1) == 0) begin
      s = "(";
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0) s = {s, ","};
        s = {s, rand_item()};
      end
      s = {s, ")"};
    end else begin
      s = rand_item();
      if (last_arg && ($urandom_range(0, 2) == 0)) s = {s, ",", rand_item()};
    end
    return s;
  endfunction

  function automatic string rand_string(input int nargs);
    string s;
    s = "";
    for (int i = 0; i < nargs; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 3) == 0) s = {s, ", "};
        else s = {s, ","};
      end
      s = {s, rand_arg(i == nargs - 1)};
    end
    if ($urandom_range(0, 3) == 0) s = {s, rand_word()};
    return s;
  endfunction

  initial begin
    int nargs;
    int directed_chars;
    parser_clear();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes, clamp, low above high, word then dot, word as range low
    set_count(1);
    send_text("(0,31-40,5-3,ab.1,ab-2)", 0);
    send_char(8'hff, 1'b1);
    // saturating decimal, dot form on the saturated value, nul as end
    set_count(2);
    send_text("999.0,3.1", 0);
    send_char(ChNul, 1'b0);
    // zero count gives ok at once, then end after finish
    set_count(0);
    send_text("x", 0);
    send_char(8'h00, 1'b1);
    // count above eight, word range low without digit after the dash
    set_count(15);
    send_text("(ab-x", 0);
    send_char(8'h5a, 1'b1);
    // character above 127 is a syntax error
    set_count(8);
    send_text("7 ", 0);
    send_char(8'h80, 1'b0);
    send_char(8'h01, 1'b1);
    // count lowered below the arguments already done
    set_count(3);
    send_text("(1)", 0);
    set_count(1);
    send_text("2", 0);
    send_char(8'h00, 1'b1);
    strings_sent += 6;
    directed_chars = chars_queued;

    while (chars_queued < directed_chars + RandomChars) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) == 0) set_count($urandom_range(0, 15));
        else set_count($urandom_range(1, 8));
      end
      fast_in  = ($urandom_range(0, 4) == 0);
      fast_out = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 12)) send_char(CharW'($urandom_range(0, 255)), 1'b0);
      end else begin
        nargs = (cur_count == 0) ? 1 : ((cur_count > 8) ? 8 : cur_count);
        if ($urandom_range(0, 5) == 0) nargs = nargs + 1;
        else if ((nargs > 1) && ($urandom_range(0, 5) == 0)) nargs = nargs - 1;
        send_text(rand_string(nargs), 30);
      end
      send_end();
    end

    wait_idle();
    $display("checked %0d result words from %0d characters in %0d strings",
             out_accepted, in_accepted, strings_sent);
    $display("argument counts %0d to %0d, %0d mismatches", count_min, count_max, err_cnt);
    if ((err_cnt == 0) && (exp_results.size() == 0)) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
